[design/lmss_pkg.sv]
// Shared types, opcodes, register indexes and reset values for the strobe sequencer.
`default_nettype none

package lmss_pkg;

    // Field widths
    localparam int unsigned OPCODE_W = 3;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned UNIT_W   = 16;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned WAIT_W   = 24;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    // Item opcodes
    localparam logic [OPCODE_W-1:0] OP_RUN       = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_BRAKE     = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POLICE_ON = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_TAIL_TGL  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_TAIL_ON   = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_OFF       = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINKS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_FACTOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_LEVEL    = 3'd4;

    // Reset values
    localparam logic [UNIT_W-1:0]  RST_UNIT_INTERVAL = 16'd50;
    localparam logic [COUNT_W-1:0] RST_BLINKS        = 8'd5;
    localparam logic [COUNT_W-1:0] RST_PAUSE_FACTOR  = 8'd3;
    localparam logic [LEVEL_W-1:0] RST_FLASH_LEVEL   = 8'd255;
    localparam logic [LEVEL_W-1:0] RST_TAIL_LEVEL    = 8'd40;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;
    localparam logic [LEVEL_W-1:0] OFF_LEVEL  = 8'd0;

    // Strobe sequencing state plus the LED levels it drives
    typedef struct packed {
        logic [TIME_W-1:0]  last_step_time;
        logic [WAIT_W-1:0]  current_wait;
        logic [COUNT_W-1:0] blinks_left;
        logic               color_select;
        logic               flash_phase;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] blue;
    } t_strobe;

    // Strobe settings taken from the configuration registers
    typedef struct packed {
        logic [UNIT_W-1:0]  unit_interval;
        logic [COUNT_W-1:0] blinks_per_color;
        logic [COUNT_W-1:0] pause_factor;
        logic [LEVEL_W-1:0] flash_level;
    } t_strobe_cfg;

endpackage

`default_nettype wire

[design/light_mode_strobe_sequencer.sv]
// Top level: mode flags, configuration registers and result register of the sequencer.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_opcode[2:0], i_now_ms[31:0]
//  result    out        o_valid / i_ready    o_red_level[7:0], o_blue_level[7:0]
//  config    in         i_cfg_wr_en          i_cfg_index[2:0], i_cfg_wdata[15:0]
//
// Each item is processed in the cycle it is accepted; its result is valid the
// next cycle. One item per cycle is sustained while results are taken: the
// mode and strobe registers update at acceptance and double as the result
// register. A new item is taken while the held result is taken in the same
// cycle. Synchronous reset restores all configuration and state to defaults.
`default_nettype none

module light_mode_strobe_sequencer
    import lmss_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire [OPCODE_W-1:0]   i_opcode,
    input  wire [TIME_W-1:0]     i_now_ms,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [LEVEL_W-1:0]   o_red_level,
    output logic [LEVEL_W-1:0]   o_blue_level,
    input  wire                  i_cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DAT_W-1:0]  i_cfg_wdata
);

    t_strobe_cfg  r_cfg;
    logic [LEVEL_W-1:0] r_tail_level;
    t_strobe      r_st, n_st;
    t_strobe      strobe_next;
    logic         r_brake, n_brake;
    logic         r_police, n_police;
    logic         r_tail, n_tail;
    logic         r_out_valid;
    logic         in_acc;

    // Accept when the result slot is empty or drains this cycle
    assign o_ready = !r_out_valid || i_ready;
    assign in_acc  = i_valid && o_ready;

    assign o_valid      = r_out_valid;
    assign o_red_level  = r_st.red;
    assign o_blue_level = r_st.blue;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unit_interval    <= RST_UNIT_INTERVAL;
            r_cfg.blinks_per_color <= RST_BLINKS;
            r_cfg.pause_factor     <= RST_PAUSE_FACTOR;
            r_cfg.flash_level      <= RST_FLASH_LEVEL;
            r_tail_level           <= RST_TAIL_LEVEL;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_UNIT_INTERVAL: r_cfg.unit_interval    <= i_cfg_wdata;
                REG_BLINKS:        r_cfg.blinks_per_color <= i_cfg_wdata[COUNT_W-1:0];
                REG_PAUSE_FACTOR:  r_cfg.pause_factor     <= i_cfg_wdata[COUNT_W-1:0];
                REG_FLASH_LEVEL:   r_cfg.flash_level      <= i_cfg_wdata[LEVEL_W-1:0];
                REG_TAIL_LEVEL:    r_tail_level           <= i_cfg_wdata[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lmss_strobe u_strobe (
        .i_cur    (r_st),
        .i_cfg    (r_cfg),
        .i_now_ms (i_now_ms),
        .o_next   (strobe_next)
    );

    // Decode the item and pick the highest-priority mode on a run
    always_comb begin
        n_st     = r_st;
        n_brake  = r_brake;
        n_police = r_police;
        n_tail   = r_tail;
        if (in_acc) begin
            unique case (i_opcode)
                OP_RUN: begin
                    if (r_brake) begin
                        n_st.red  = FULL_LEVEL;
                        n_st.blue = OFF_LEVEL;
                        n_brake   = 1'b0;
                    end else if (r_police) begin
                        n_st = strobe_next;
                    end else if (r_tail) begin
                        n_st.red  = r_tail_level;
                        n_st.blue = OFF_LEVEL;
                    end else begin
                        n_st.red  = OFF_LEVEL;
                        n_st.blue = OFF_LEVEL;
                    end
                end
                OP_BRAKE:     n_brake  = 1'b1;
                OP_POLICE_ON: n_police = 1'b1;
                OP_TAIL_TGL:  n_tail   = ~r_tail;
                OP_TAIL_ON: begin
                    n_tail   = 1'b1;
                    n_police = 1'b0;
                end
                OP_OFF: begin
                    n_tail   = 1'b0;
                    n_police = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Hold state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.last_step_time <= '0;
            r_st.current_wait   <= {{(WAIT_W-UNIT_W){1'b0}}, RST_UNIT_INTERVAL};
            r_st.blinks_left    <= RST_BLINKS;
            r_st.color_select   <= 1'b0;
            r_st.flash_phase    <= 1'b0;
            r_st.red            <= OFF_LEVEL;
            r_st.blue           <= OFF_LEVEL;
            r_brake             <= 1'b0;
            r_police            <= 1'b0;
            r_tail              <= 1'b0;
            r_out_valid         <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_brake  <= n_brake;
            r_police <= n_police;
            r_tail   <= n_tail;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input stalls only behind a held, untaken result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_out_valid && !i_ready))
        else $error("input stalled without a pending result");

    // A brake item leaves a pending request
    a_brake_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_opcode == OP_BRAKE) |=> r_brake)
        else $error("brake request not latched");

    // A run with a pending brake gives full red, blue off
    a_brake_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_opcode == OP_RUN && r_brake)
        |=> (o_valid && o_red_level == FULL_LEVEL && o_blue_level == OFF_LEVEL && !r_brake))
        else $error("brake result wrong");

    // Off clears both police and tail modes
    a_off_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_opcode == OP_OFF) |=> (!r_police && !r_tail))
        else $error("off item left a mode active");

    // Strobe state and levels move only on an accepted item
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_st))
        else $error("state changed without an item");

endmodule

`default_nettype wire

[design/lmss_strobe.sv]
// Next-state logic of one police strobe step.
`default_nettype none

module lmss_strobe
    import lmss_pkg::*;
(
    input  wire t_strobe          i_cur,
    input  wire t_strobe_cfg      i_cfg,
    input  wire [TIME_W-1:0]      i_now_ms,
    output t_strobe               o_next
);

    logic [TIME_W-1:0]  elapsed;
    logic               fire;
    logic [WAIT_W-1:0]  pause_wait;
    logic [COUNT_W-1:0] blinks_upd;

    // Compare wrapped elapsed time against the current wait
    assign elapsed = i_now_ms - i_cur.last_step_time;
    assign fire    = elapsed > {{(TIME_W-WAIT_W){1'b0}}, i_cur.current_wait};

    // Pause after a color run; 8x16 product always fits the wait width
    assign pause_wait = WAIT_W'(i_cfg.pause_factor * i_cfg.unit_interval);

    // Count down a blink at each dark phase
    assign blinks_upd = i_cur.flash_phase ? (i_cur.blinks_left - COUNT_W'(1))
                                          : i_cur.blinks_left;

    // Advance one step when the wait has run out
    always_comb begin
        o_next = i_cur;
        if (fire) begin
            o_next.last_step_time = i_now_ms;
            o_next.blinks_left    = blinks_upd;
            if (!i_cur.flash_phase) begin
                if (!i_cur.color_select) begin
                    o_next.red = i_cfg.flash_level;
                end else begin
                    o_next.blue = i_cfg.flash_level;
                end
            end else begin
                o_next.red  = OFF_LEVEL;
                o_next.blue = OFF_LEVEL;
            end
            o_next.flash_phase = ~i_cur.flash_phase;
            if (blinks_upd == '0) begin
                o_next.blinks_left  = i_cfg.blinks_per_color;
                o_next.color_select = ~i_cur.color_select;
                o_next.current_wait = pause_wait;
            end else begin
                o_next.current_wait = {{(WAIT_W-UNIT_W){1'b0}}, i_cfg.unit_interval};
            end
        end
    end

endmodule

`default_nettype wire

[test/light_mode_strobe_sequencer_tb.sv]
// Self-checking testbench for the light mode strobe sequencer: LED level prediction and checks.
module light_mode_strobe_sequencer_tb
    import lmss_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes and register indexes that the block ignores
    localparam logic [OPCODE_W-1:0]  OP_SPARE_A      = 3'd6;
    localparam logic [OPCODE_W-1:0]  OP_SPARE_B      = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam int CYCLE_LIMIT     = 100_000;
    localparam int PHASE_COUNT     = 7;
    localparam int ITEMS_PER_PHASE = 115;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] blue;
    } t_led_pair;

    // LED level predictor and result store
    class t_strobe_scoreboard;
        logic [UNIT_W-1:0]  unit_interval;
        logic [COUNT_W-1:0] blinks_per_color;
        logic [COUNT_W-1:0] pause_factor;
        logic [LEVEL_W-1:0] flash_level;
        logic [LEVEL_W-1:0] tail_level;

        logic               brake_pending;
        logic               police;
        logic               tail;
        logic [TIME_W-1:0]  last_time;
        logic [WAIT_W-1:0]  cur_wait;
        logic [COUNT_W-1:0] blinks_left;
        logic               color_blue;
        logic               dark_phase;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] blue;

        t_led_pair levels_due[$];
        int errors;
        int results;
        int steps;
        int swaps;

        function new();
            unit_interval    = RST_UNIT_INTERVAL;
            blinks_per_color = RST_BLINKS;
            pause_factor     = RST_PAUSE_FACTOR;
            flash_level      = RST_FLASH_LEVEL;
            tail_level       = RST_TAIL_LEVEL;
            brake_pending    = 1'b0;
            police           = 1'b0;
            tail             = 1'b0;
            last_time        = '0;
            cur_wait         = WAIT_W'(RST_UNIT_INTERVAL);
            blinks_left      = RST_BLINKS;
            color_blue       = 1'b0;
            dark_phase       = 1'b0;
            red              = OFF_LEVEL;
            blue             = OFF_LEVEL;
            errors           = 0;
            results          = 0;
            steps            = 0;
            swaps            = 0;
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_UNIT_INTERVAL: unit_interval    = data[UNIT_W-1:0];
                REG_BLINKS:        blinks_per_color = data[COUNT_W-1:0];
                REG_PAUSE_FACTOR:  pause_factor     = data[COUNT_W-1:0];
                REG_FLASH_LEVEL:   flash_level      = data[LEVEL_W-1:0];
                REG_TAIL_LEVEL:    tail_level       = data[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the strobe once the wrapped elapsed time exceeds the wait
        function void strobe_tick(logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] elapsed;
            logic [WAIT_W-1:0] pause;
            elapsed = now - last_time;
            if (elapsed <= {8'd0, cur_wait}) return;
            steps++;
            last_time = now;
            if (!dark_phase) begin
                if (color_blue) blue = flash_level;
                else red = flash_level;
            end else begin
                red = OFF_LEVEL;
                blue = OFF_LEVEL;
                blinks_left = blinks_left - 8'd1;
            end
            dark_phase = ~dark_phase;
            if (blinks_left == '0) begin
                swaps++;
                blinks_left = blinks_per_color;
                color_blue = ~color_blue;
                pause = pause_factor * unit_interval;
                cur_wait = pause;
            end else begin
                cur_wait = WAIT_W'(unit_interval);
            end
        endfunction

        // Apply one accepted item and queue the levels it leaves behind
        function void note_item(logic [OPCODE_W-1:0] op, logic [TIME_W-1:0] now);
            case (op)
                OP_RUN: begin
                    if (brake_pending) begin
                        red = FULL_LEVEL;
                        blue = OFF_LEVEL;
                        brake_pending = 1'b0;
                    end else if (police) begin
                        strobe_tick(now);
                    end else if (tail) begin
                        red = tail_level;
                        blue = OFF_LEVEL;
                    end else begin
                        red = OFF_LEVEL;
                        blue = OFF_LEVEL;
                    end
                end
                OP_BRAKE:     brake_pending = 1'b1;
                OP_POLICE_ON: police = 1'b1;
                OP_TAIL_TGL:  tail = ~tail;
                OP_TAIL_ON: begin
                    tail = 1'b1;
                    police = 1'b0;
                end
                OP_OFF: begin
                    tail = 1'b0;
                    police = 1'b0;
                end
                default: ;
            endcase
            levels_due.push_back(t_led_pair'{red: red, blue: blue});
        endfunction

        // Compare one result with the oldest queued levels
        function void check_result(logic [LEVEL_W-1:0] red_got,
                                   logic [LEVEL_W-1:0] blue_got);
            t_led_pair want;
            results++;
            if (levels_due.size() == 0) begin
                errors++;
                $display("%0t: result with nothing queued, red %0d blue %0d",
                         $time, red_got, blue_got);
                return;
            end
            want = levels_due.pop_front();
            if (red_got !== want.red) begin
                errors++;
                $display("%0t: red_level expected %0d, got %0d", $time, want.red, red_got);
            end
            if (blue_got !== want.blue) begin
                errors++;
                $display("%0t: blue_level expected %0d, got %0d", $time, want.blue, blue_got);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [OPCODE_W-1:0]  i_opcode;
    logic [TIME_W-1:0]    i_now_ms;
    logic                 o_valid;
    logic                 i_ready;
    logic [LEVEL_W-1:0]   o_red_level;
    logic [LEVEL_W-1:0]   o_blue_level;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;

    t_strobe_scoreboard sb;
    int  cycle_count = 0;
    int  items_sent = 0;
    int  settings_used = 1;
    int  ready_hold = 0;
    bit  steady = 1'b0;

    light_mode_strobe_sequencer i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_now_ms     (i_now_ms),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red_level  (o_red_level),
        .o_blue_level (o_blue_level),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // End the run if it hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    // Drive result ready: random stalls, steady stretch, long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (ready_hold > 0) begin
                i_ready <= 1'b0;
                ready_hold--;
            end else if (steady) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // Check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_red_level, o_blue_level);
    end

    // Offer one item and hold it until accepted
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [TIME_W-1:0] now);
        if (!steady && $urandom_range(0, 99) < 20) begin
            repeat ($urandom_range(1, 2)) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_now_ms <= now;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(op, now);
        items_sent++;
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic load_settings(input logic [CFG_DAT_W-1:0] unit,
                                 input logic [CFG_DAT_W-1:0] blinks,
                                 input logic [CFG_DAT_W-1:0] pause,
                                 input logic [CFG_DAT_W-1:0] flash,
                                 input logic [CFG_DAT_W-1:0] tail_duty);
        write_reg(REG_UNIT_INTERVAL, unit);
        write_reg(REG_BLINKS, blinks);
        write_reg(REG_PAUSE_FACTOR, pause);
        write_reg(REG_FLASH_LEVEL, flash);
        write_reg(REG_TAIL_LEVEL, tail_duty);
        settings_used++;
    endtask

    // Pick a random item: mostly run items timed around the pending strobe wait
    task automatic pick_item(output logic [OPCODE_W-1:0] op, output logic [TIME_W-1:0] now);
        int unsigned r;
        logic [TIME_W-1:0] w;
        r = $urandom_range(0, 99);
        w = {8'd0, sb.cur_wait};
        now = $urandom;
        if (r < 58) begin
            op = OP_RUN;
            case ($urandom_range(0, 5))
                0: now = sb.last_time + w;
                1: now = sb.last_time + w + 32'd1;
                2: now = sb.last_time + $urandom_range(0, w);
                3: now = sb.last_time + w + 32'd1 + $urandom_range(0, w);
                4: now = $urandom;
                default: now = sb.last_time + $urandom_range(0, 3);
            endcase
        end else if (r < 68) begin
            op = OP_POLICE_ON;
        end else if (r < 74) begin
            op = OP_BRAKE;
        end else if (r < 80) begin
            op = OP_TAIL_TGL;
        end else if (r < 85) begin
            op = OP_TAIL_ON;
        end else if (r < 90) begin
            op = OP_OFF;
        end else if (r < 94) begin
            op = ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
        end else begin
            op = OPCODE_W'($urandom_range(0, 7));
        end
    endtask

    // Main sequence
    initial begin
        logic [OPCODE_W-1:0] op;
        logic [TIME_W-1:0]   now;
        int                  phase;

        sb = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_opcode    = OP_RUN;
        i_now_ms    = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = REG_UNIT_INTERVAL;
        i_cfg_wdata = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ignored opcodes, tail, brake priority, strobe wait edge and time wrap
        send_item(OP_RUN,       32'd0);
        send_item(OP_SPARE_A,   32'hFFFF_FFFF);
        send_item(OP_SPARE_B,   32'd0);
        send_item(OP_TAIL_ON,   32'h1234_5678);
        send_item(OP_RUN,       32'd10);
        send_item(OP_TAIL_TGL,  32'd0);
        send_item(OP_RUN,       32'd20);
        send_item(OP_TAIL_TGL,  32'hFFFF_FFFF);
        send_item(OP_BRAKE,     32'd0);
        send_item(OP_RUN,       32'd30);
        send_item(OP_RUN,       32'd40);
        send_item(OP_POLICE_ON, 32'd0);
        send_item(OP_RUN,       32'd50);
        send_item(OP_RUN,       32'd51);
        send_item(OP_RUN,       32'hFFFF_FFFF);
        send_item(OP_RUN,       32'h0000_0031);
        send_item(OP_RUN,       32'h0000_0032);
        send_item(OP_BRAKE,     32'hAAAA_AAAA);
        send_item(OP_RUN,       32'h0000_0040);
        send_item(OP_RUN,       32'h0000_0100);
        send_item(OP_OFF,       32'h5555_5555);
        send_item(OP_RUN,       32'd0);

        // Random phases, each under its own register setting
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_idle();
            steady = 1'b0;
            case (phase)
                1: load_settings(16'd1, 16'd1, 16'd1, 16'd0, 16'd0);
                2: load_settings(16'hFFFF, 16'd255, 16'd255, 16'd255, 16'd255);
                3: begin
                    load_settings(16'd0, 16'd0, 16'd0, 16'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 255)));
                    steady = 1'b1;
                end
                4: begin
                    load_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom));
                    write_reg(REG_SPARE_FIRST, 16'($urandom));
                    write_reg(REG_SPARE_LAST, 16'hFFFF);
                end
                5: begin
                    load_settings(16'($urandom_range(1, 8)), 16'($urandom_range(1, 4)),
                                  16'($urandom_range(0, 3)), 16'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 255)));
                    // Hold results off so the block backs up onto its input
                    ready_hold = 300;
                end
                6: load_settings(16'($urandom_range(1, 300)), 16'($urandom_range(1, 10)),
                                 16'($urandom_range(1, 10)), 16'($urandom_range(0, 255)),
                                 16'($urandom_range(0, 255)));
                default: ;
            endcase
            repeat (ITEMS_PER_PHASE) begin
                pick_item(op, now);
                send_item(op, now);
            end
        end

        // Drain and report
        wait_idle();
        repeat (5) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.pending());
        end
        $display("Sent %0d items, checked %0d results under %0d register settings",
                 items_sent, sb.results, settings_used);
        $display("Strobe advanced %0d times with %0d color swaps, %0d mismatches",
                 sb.steps, sb.swaps, sb.errors);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
